// ----- hdl/hflut_pkg.sv -----
package hflut_pkg;

    localparam logic [27:0] HEADER_BYTES  = 28'd12;
    localparam logic [27:0] COUNT_MAX     = 28'h0FFF_FFFF;
    localparam logic [31:0] MIN_DIMENSION = 32'd2;
    localparam logic [31:0] MAX_DIMENSION = 32'd256;
    localparam logic [31:0] RESERVED_VALUE = 32'd0;
    localparam int          QUEUE_DEPTH   = 2;

    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNCATED = 3'd1,
        ST_RESERVED  = 3'd2,
        ST_DIMENSION = 3'd3,
        ST_SCALE     = 3'd4,
        ST_LENGTH    = 3'd5,
        ST_NONFINITE = 3'd6
    } t_status;

    typedef enum logic {
        BK_CHANNEL = 1'b0,
        BK_STATUS  = 1'b1
    } t_back_state;

    // One queue entry: an optional channel followed by an optional final status
    typedef struct packed {
        logic        ch_valid;
        logic [15:0] half;
        logic [25:0] ch_num;
        logic        st_valid;
        t_status     status;
        logic [8:0]  dim;
        logic [31:0] scale;
        logic [25:0] st_num;
    } t_qentry;

endpackage

// ----- hdl/half_float_lut_stream_parser.sv -----
// Streaming parser for a binary colour LUT: one byte per accepted item, with a
// last flag. The front checks the 12-byte little-endian header, forms the
// expected length 12 + 8*dim^3 (the cube is built by a two-stage multiplier
// while the scale bytes arrive) and queues each complete half-precision
// channel; the back widens it to single precision and presents it with its
// index through a registered output. The byte marked last also produces a
// status result, and the parser then starts afresh. Bytes are accepted at one
// per cycle; a last byte that also completes a channel yields a channel result
// and then a status result, and the input stalls only when the two-entry
// queue is full. Each result passes through the queue and then the output
// register. Channels are valid only when the final status reads ok.
module half_float_lut_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [31:0] o_channel_bits,
    output logic [25:0] o_channel_number,
    output logic [2:0]  o_status,
    output logic [8:0]  o_lut_dimension,
    output logic [31:0] o_scale_bits,
    output logic        o_end_of_run
);

    logic               accept;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               head_valid;
    hflut_pkg::t_qentry entry;
    hflut_pkg::t_qentry head;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    hflut_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .o_push      (push),
        .o_entry     (entry)
    );

    hflut_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    hflut_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_channel_bits   (o_channel_bits),
        .o_channel_number (o_channel_number),
        .o_status         (o_status),
        .o_lut_dimension  (o_lut_dimension),
        .o_scale_bits     (o_scale_bits),
        .o_end_of_run     (o_end_of_run)
    );

endmodule

// ----- hdl/hflut_front.sv -----
module hflut_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_is_last,
    output logic              o_push,
    output hflut_pkg::t_qentry o_entry
);

    logic [27:0]        r_byte_cnt, n_byte_cnt;
    logic [31:0]        r_reserved, n_reserved;
    logic [31:0]        r_dim, n_dim;
    logic [31:0]        r_scale, n_scale;
    logic [27:0]        r_exp_len, n_exp_len;
    logic [7:0]         r_low, n_low;
    hflut_pkg::t_status r_held, n_held;
    logic [25:0]        r_chan_cnt, n_chan_cnt;
    logic [16:0]        r_dsq;
    logic [24:0]        r_cube;

    logic [4:0]         lane;
    logic               dim_ok;
    logic               scale_bad;
    logic               full;
    logic               emit_ch;
    hflut_pkg::t_status fin_status;

    assign lane   = {r_byte_cnt[1:0], 3'b000};
    assign dim_ok = (r_dim >= hflut_pkg::MIN_DIMENSION) && (r_dim <= hflut_pkg::MAX_DIMENSION);

    // Cube of the dimension, settled over the scale bytes
    always_ff @(posedge i_clk) begin
        r_dsq  <= {8'd0, r_dim[8:0]} * {8'd0, r_dim[8:0]};
        r_cube <= {8'd0, r_dsq} * {16'd0, r_dim[8:0]};
    end

    always_comb begin
        n_byte_cnt = r_byte_cnt;
        n_reserved = r_reserved;
        n_dim      = r_dim;
        n_scale    = r_scale;
        n_exp_len  = r_exp_len;
        n_low      = r_low;
        n_held     = r_held;
        n_chan_cnt = r_chan_cnt;
        emit_ch    = 1'b0;
        scale_bad  = 1'b0;
        full       = 1'b0;
        fin_status = hflut_pkg::ST_OK;
        o_push     = 1'b0;
        o_entry    = '0;
        o_entry.half   = {i_data_byte, r_low};
        o_entry.ch_num = r_chan_cnt;

        if (i_accept) begin
            if (r_byte_cnt < 28'd4) begin
                n_reserved[lane +: 8] = i_data_byte;
            end else if (r_byte_cnt < 28'd8) begin
                n_dim[lane +: 8] = i_data_byte;
            end else if (r_byte_cnt < hflut_pkg::HEADER_BYTES) begin
                n_scale[lane +: 8] = i_data_byte;
            end else if (!r_byte_cnt[0]) begin
                n_low = i_data_byte;
            end else if (r_held == hflut_pkg::ST_OK && r_byte_cnt < r_exp_len) begin
                emit_ch    = 1'b1;
                n_chan_cnt = r_chan_cnt + 26'd1;
                if (i_data_byte[6:2] == 5'h1F) begin
                    n_held = hflut_pkg::ST_NONFINITE;
                end
            end

            if (r_byte_cnt == hflut_pkg::HEADER_BYTES - 28'd1) begin
                scale_bad = n_scale[31] || (n_scale[30:23] == 8'hFF) || (n_scale == 32'd0);
                if (r_reserved != hflut_pkg::RESERVED_VALUE) begin
                    n_held = hflut_pkg::ST_RESERVED;
                end else if (!dim_ok) begin
                    n_held = hflut_pkg::ST_DIMENSION;
                end else if (scale_bad) begin
                    n_held = hflut_pkg::ST_SCALE;
                end else begin
                    n_exp_len = hflut_pkg::HEADER_BYTES + {r_cube, 3'b000};
                end
            end

            if (r_byte_cnt != hflut_pkg::COUNT_MAX) begin
                n_byte_cnt = r_byte_cnt + 28'd1;
            end

            o_entry.ch_valid = emit_ch;

            if (i_is_last) begin
                full = n_byte_cnt >= hflut_pkg::HEADER_BYTES;
                if (!full) begin
                    fin_status = hflut_pkg::ST_TRUNCATED;
                end else if (n_held == hflut_pkg::ST_RESERVED ||
                             n_held == hflut_pkg::ST_DIMENSION ||
                             n_held == hflut_pkg::ST_SCALE) begin
                    fin_status = n_held;
                end else if (n_byte_cnt != n_exp_len) begin
                    fin_status = hflut_pkg::ST_LENGTH;
                end else begin
                    fin_status = n_held;
                end
                o_entry.st_valid = 1'b1;
                o_entry.status   = fin_status;
                o_entry.dim      = (full && dim_ok) ? r_dim[8:0] : 9'd0;
                o_entry.scale    = n_scale;
                o_entry.st_num   = n_chan_cnt;

                // Return to the reset state for the next file
                n_byte_cnt = '0;
                n_reserved = '0;
                n_dim      = '0;
                n_scale    = '0;
                n_exp_len  = '0;
                n_low      = '0;
                n_held     = hflut_pkg::ST_OK;
                n_chan_cnt = '0;
            end

            o_push = emit_ch || i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_reserved <= '0;
            r_dim      <= '0;
            r_scale    <= '0;
            r_exp_len  <= '0;
            r_low      <= '0;
            r_held     <= hflut_pkg::ST_OK;
            r_chan_cnt <= '0;
        end else begin
            r_byte_cnt <= n_byte_cnt;
            r_reserved <= n_reserved;
            r_dim      <= n_dim;
            r_scale    <= n_scale;
            r_exp_len  <= n_exp_len;
            r_low      <= n_low;
            r_held     <= n_held;
            r_chan_cnt <= n_chan_cnt;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_is_last) |=> (r_byte_cnt == 28'd0 && r_chan_cnt == 26'd0))
        else $error("state not cleared after final item");

    a_error_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != hflut_pkg::ST_OK) |-> (r_byte_cnt >= hflut_pkg::HEADER_BYTES))
        else $error("error held before header complete");

    a_nonfinite_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == hflut_pkg::ST_NONFINITE) |-> (r_exp_len != 28'd0))
        else $error("nonfinite error without a valid header");

endmodule

// ----- hdl/hflut_queue.sv -----
module hflut_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hflut_pkg::t_qentry i_entry,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_head_valid,
    output hflut_pkg::t_qentry o_head
);

    localparam int PTR_W = (hflut_pkg::QUEUE_DEPTH > 1) ? $clog2(hflut_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hflut_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(hflut_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(hflut_pkg::QUEUE_DEPTH);

    hflut_pkg::t_qentry r_mem [hflut_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full       = r_count == DEPTH_CNT;
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

endmodule

// ----- hdl/hflut_back.sv -----
module hflut_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  hflut_pkg::t_qentry i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [31:0]        o_channel_bits,
    output logic [25:0]        o_channel_number,
    output logic [2:0]         o_status,
    output logic [8:0]         o_lut_dimension,
    output logic [31:0]        o_scale_bits,
    output logic               o_end_of_run
);

    hflut_pkg::t_back_state r_state, n_state;
    logic        r_valid, n_valid;
    logic        r_kind, n_kind;
    logic [31:0] r_bits, n_bits;
    logic [25:0] r_num, n_num;
    logic [2:0]  r_status, n_status;
    logic [8:0]  r_dim, n_dim;
    logic [31:0] r_scale, n_scale;
    logic        r_end, n_end;
    logic        load;
    logic        take_status;

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic       sgn;
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] p;
        logic [9:0] mn;
        logic [7:0] ef;
        sgn = h[15];
        e   = h[14:10];
        m   = h[9:0];
        p   = 4'd0;
        for (int k = 0; k < 10; k++) begin
            if (m[k]) begin
                p = 4'(k);
            end
        end
        if (e == 5'd0) begin
            if (m == 10'd0) begin
                return {sgn, 31'd0};
            end
            // Normalise the subnormal: leading one becomes implicit
            mn = m << (4'd10 - p);
            ef = 8'd103 + {4'd0, p};
            return {sgn, ef, mn, 13'd0};
        end
        if (e == 5'h1F) begin
            return {sgn, 8'hFF, m, 13'd0};
        end
        ef = {3'd0, e} + 8'd112;
        return {sgn, ef, m, 13'd0};
    endfunction

    always_comb begin
        load        = !r_valid || !i_stall;
        n_state     = r_state;
        n_valid     = r_valid && i_stall;
        n_kind      = r_kind;
        n_bits      = r_bits;
        n_num       = r_num;
        n_status    = r_status;
        n_dim       = r_dim;
        n_scale     = r_scale;
        n_end       = r_end;
        o_pop       = 1'b0;
        take_status = 1'b0;

        if (load && i_head_valid) begin
            n_valid = 1'b1;
            case (r_state)
                hflut_pkg::BK_CHANNEL: begin
                    if (i_head.ch_valid) begin
                        n_kind   = hflut_pkg::KIND_CHANNEL;
                        n_bits   = widen_half(i_head.half);
                        n_num    = i_head.ch_num;
                        n_status = hflut_pkg::ST_OK;
                        n_dim    = 9'd0;
                        n_scale  = 32'd0;
                        n_end    = 1'b0;
                        // Hold the entry when its status is still to go
                        if (i_head.st_valid) begin
                            n_state = hflut_pkg::BK_STATUS;
                        end else begin
                            o_pop = 1'b1;
                        end
                    end else begin
                        take_status = 1'b1;
                    end
                end
                hflut_pkg::BK_STATUS: begin
                    take_status = 1'b1;
                end
                default: begin
                    take_status = 1'b1;
                end
            endcase
            if (take_status) begin
                n_kind   = hflut_pkg::KIND_STATUS;
                n_bits   = 32'd0;
                n_num    = i_head.st_num;
                n_status = i_head.status;
                n_dim    = i_head.dim;
                n_scale  = i_head.scale;
                n_end    = 1'b1;
                n_state  = hflut_pkg::BK_CHANNEL;
                o_pop    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hflut_pkg::BK_CHANNEL;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_bits   <= n_bits;
        r_num    <= n_num;
        r_status <= n_status;
        r_dim    <= n_dim;
        r_scale  <= n_scale;
        r_end    <= n_end;
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_channel_bits   = r_bits;
    assign o_channel_number = r_num;
    assign o_status         = r_status;
    assign o_lut_dimension  = r_dim;
    assign o_scale_bits     = r_scale;
    assign o_end_of_run     = r_end;

    a_status_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hflut_pkg::BK_STATUS) |->
            (i_head_valid && i_head.ch_valid && i_head.st_valid))
        else $error("status phase without a matching entry");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;
    } t_byte_item;

    typedef struct packed {
        logic               kind;
        logic [31:0]        channel_bits;
        logic [25:0]        channel_number;
        hflut_pkg::t_status status;
        logic [8:0]         lut_dimension;
        logic [31:0]        scale_bits;
        logic               end_of_run;
    } t_lut_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_is_last   = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_kind;
    logic [31:0] o_channel_bits;
    logic [25:0] o_channel_number;
    logic [2:0]  o_status;
    logic [8:0]  o_lut_dimension;
    logic [31:0] o_scale_bits;
    logic        o_end_of_run;

    half_float_lut_stream_parser i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_is_last        (i_is_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_channel_bits   (o_channel_bits),
        .o_channel_number (o_channel_number),
        .o_status         (o_status),
        .o_lut_dimension  (o_lut_dimension),
        .o_scale_bits     (o_scale_bits),
        .o_end_of_run     (o_end_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Parser state as predicted
    logic [27:0]        byte_cnt   = '0;
    logic [31:0]        rsv_word   = '0;
    logic [31:0]        dim_word   = '0;
    logic [31:0]        scale_word = '0;
    logic [27:0]        exp_len    = '0;
    logic [7:0]         low_byte   = '0;
    hflut_pkg::t_status held_err   = hflut_pkg::ST_OK;
    logic [25:0]        chan_cnt   = '0;

    t_byte_item  file_bytes[$];
    logic [7:0]  file_buf[$];
    t_lut_result lut_results_due[$];

    int error_count      = 0;
    int channels_checked = 0;
    int statuses_checked = 0;
    int file_count       = 0;
    int bytes_accepted   = 0;
    int bytes_offered    = 0;
    int cycle_count      = 0;
    int gap_left         = 0;
    int stall_left       = 0;
    int status_tally[0:7];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0] e;
        logic [9:0] m;
        logic [9:0] frac;
        int         lead;
        e = h[14:10];
        m = h[9:0];
        if (e == 5'd0) begin
            if (m == 10'd0)
                return {h[15], 31'd0};
            // normalise the subnormal on its leading one
            lead = 0;
            for (int k = 0; k < 10; k++)
                if (m[k])
                    lead = k;
            frac = m << (10 - lead);
            return {h[15], 8'(103 + lead), frac, 13'd0};
        end
        if (e == 5'h1F)
            return {h[15], 8'hFF, m, 13'd0};
        return {h[15], 8'(e + 112), m, 13'd0};
    endfunction

    function automatic logic dim_ok(input logic [31:0] d);
        return d >= hflut_pkg::MIN_DIMENSION && d <= hflut_pkg::MAX_DIMENSION;
    endfunction

    task automatic clear_parser();
        byte_cnt   = '0;
        rsv_word   = '0;
        dim_word   = '0;
        scale_word = '0;
        exp_len    = '0;
        low_byte   = '0;
        held_err   = hflut_pkg::ST_OK;
        chan_cnt   = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [27:0]        idx;
        logic [31:0]        wide;
        logic [31:0]        cube;
        logic               complete;
        hflut_pkg::t_status st;
        t_lut_result        r;
        idx = byte_cnt;
        if (idx < 28'd4)
            rsv_word = rsv_word | ({24'd0, b} << (8 * idx[1:0]));
        else if (idx < 28'd8)
            dim_word = dim_word | ({24'd0, b} << (8 * idx[1:0]));
        else if (idx < hflut_pkg::HEADER_BYTES)
            scale_word = scale_word | ({24'd0, b} << (8 * idx[1:0]));
        else if (!idx[0])
            low_byte = b;
        else if (held_err == hflut_pkg::ST_OK && idx < exp_len) begin
            wide = half_to_single({b, low_byte});
            r = '0;
            r.kind = hflut_pkg::KIND_CHANNEL;
            r.channel_bits = wide;
            r.channel_number = chan_cnt;
            r.status = hflut_pkg::ST_OK;
            lut_results_due.push_back(r);
            chan_cnt = chan_cnt + 26'd1;
            if (wide[30:23] == 8'hFF)
                held_err = hflut_pkg::ST_NONFINITE;
        end
        if (idx == hflut_pkg::HEADER_BYTES - 28'd1) begin
            if (rsv_word != hflut_pkg::RESERVED_VALUE)
                held_err = hflut_pkg::ST_RESERVED;
            else if (!dim_ok(dim_word))
                held_err = hflut_pkg::ST_DIMENSION;
            else if (scale_word[31] || scale_word[30:23] == 8'hFF || scale_word == 32'd0)
                held_err = hflut_pkg::ST_SCALE;
            else begin
                cube = dim_word * dim_word * dim_word;
                exp_len = 28'(32'd12 + (cube << 3));
            end
        end
        if (byte_cnt < hflut_pkg::COUNT_MAX)
            byte_cnt = byte_cnt + 28'd1;
        if (last) begin
            complete = byte_cnt >= hflut_pkg::HEADER_BYTES;
            if (!complete)
                st = hflut_pkg::ST_TRUNCATED;
            else if (held_err >= hflut_pkg::ST_RESERVED && held_err <= hflut_pkg::ST_SCALE)
                st = held_err;
            else if (byte_cnt != exp_len)
                st = hflut_pkg::ST_LENGTH;
            else
                st = held_err;
            r = '0;
            r.kind = hflut_pkg::KIND_STATUS;
            r.channel_number = chan_cnt;
            r.status = st;
            r.lut_dimension = (complete && dim_ok(dim_word)) ? dim_word[8:0] : 9'd0;
            r.scale_bits = scale_word;
            r.end_of_run = 1'b1;
            lut_results_due.push_back(r);
            status_tally[st]++;
            clear_parser();
        end
    endtask

    function automatic logic calm_stretch();
        return ((cycle_count / 300) % 4) == 3;
    endfunction

    function automatic int burst_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        if (calm_stretch() || $urandom_range(0, 99) < 65)
            return 0;
        return burst_len();
    endfunction

    function automatic logic [15:0] random_half();
        int r;
        r = $urandom_range(0, 999);
        if (r < 8)
            return {1'($urandom), 5'h1F, 10'($urandom)};
        if (r < 100)
            return {1'($urandom), 15'd0};
        if (r < 250)
            return {1'($urandom), 5'd0, 10'($urandom_range(1, 1023))};
        return {1'($urandom), 5'($urandom_range(1, 30)), 10'($urandom)};
    endfunction

    function automatic logic [31:0] good_scale();
        int r;
        logic [31:0] s;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0001;
        if (r == 1)
            return 32'h7F7F_FFFF;
        s = {1'b0, 8'($urandom_range(0, 254)), 23'($urandom)};
        return (s == 32'd0) ? 32'h3F80_0000 : s;
    endfunction

    task automatic add_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            file_buf.push_back(w[8*k +: 8]);
    endtask

    task automatic add_halves(input int nbytes);
        logic [15:0] h;
        int          n;
        n = 0;
        while (n < nbytes) begin
            h = random_half();
            file_buf.push_back(h[7:0]);
            n++;
            if (n < nbytes) begin
                file_buf.push_back(h[15:8]);
                n++;
            end
        end
    endtask

    task automatic add_random_bytes(input int nbytes);
        for (int k = 0; k < nbytes; k++)
            file_buf.push_back(8'($urandom));
    endtask

    // Move the built file into the send queue, last flag on its final byte
    task automatic commit_file(input bit hold);
        t_byte_item it;
        for (int k = 0; k < file_buf.size(); k++) begin
            it.data = file_buf[k];
            it.last = (k == file_buf.size() - 1);
            it.hold = hold && (k == 0);
            file_bytes.push_back(it);
        end
        file_buf.delete();
        file_count++;
    endtask

    task automatic add_bad_header();
        case ($urandom_range(0, 2))
            0: begin
                if ($urandom_range(0, 1))
                    add_word(32'd1 << $urandom_range(0, 31));
                else
                    add_word($urandom | 32'd1);
                add_word($urandom_range(2, 256));
                add_word(good_scale());
            end
            1: begin
                add_word(32'd0);
                case ($urandom_range(0, 4))
                    0: add_word(32'd0);
                    1: add_word(32'd1);
                    2: add_word(32'd257);
                    3: add_word(32'hFFFF_FFFF);
                    default: add_word($urandom | 32'h200);
                endcase
                add_word(good_scale());
            end
            default: begin
                add_word(32'd0);
                add_word($urandom_range(2, 256));
                case ($urandom_range(0, 2))
                    0: add_word({1'b1, 31'($urandom)});
                    1: add_word({1'($urandom), 8'hFF, 23'($urandom)});
                    default: add_word(32'd0);
                endcase
            end
        endcase
    endtask

    initial begin : fill_stimulus
        int pick;
        int body;
        int n;
        bit hold;
        foreach (status_tally[k])
            status_tally[k] = 0;

        // truncated after one byte
        file_buf.push_back(8'hFF);
        commit_file(1'b0);
        // largest cube, an infinite channel then a short file; drain first
        add_word(32'd0);
        add_word(32'd256);
        add_word(32'h3F80_0000);
        file_buf.push_back(8'h00);
        file_buf.push_back(8'h7C);
        commit_file(1'b1);
        // reserved word wrong, header only
        add_word(32'hFFFF_FFFF);
        add_word(32'd2);
        add_word(32'h3F80_0000);
        commit_file(1'b0);

        while (file_bytes.size() < 500) begin
            pick = $urandom_range(0, 99);
            hold = ($urandom_range(0, 9) == 0);
            if (pick < 40) begin
                add_word(32'd0);
                add_word(32'd2);
                add_word(good_scale());
                add_halves(64);
            end else if (pick < 52) begin
                body = $urandom_range(0, 88);
                if (body == 64)
                    body = 65;
                add_word(32'd0);
                add_word(32'd2);
                add_word(good_scale());
                add_halves(body);
            end else if (pick < 55) begin
                add_word(32'd0);
                add_word(32'd3);
                add_word(good_scale());
                add_halves(216);
            end else if (pick < 60) begin
                add_word(32'd0);
                add_word($urandom_range(4, 256));
                add_word(good_scale());
                add_halves($urandom_range(0, 20));
            end else if (pick < 80) begin
                add_bad_header();
                add_halves($urandom_range(0, 10));
            end else if (pick < 90) begin
                n = $urandom_range(1, 11);
                if ($urandom_range(0, 1)) begin
                    add_word(32'd0);
                    add_word(32'd2);
                    add_word(good_scale());
                    while (file_buf.size() > n)
                        void'(file_buf.pop_back());
                end else
                    add_random_bytes(n);
            end else
                add_random_bytes($urandom_range(1, 40));
            commit_file(hold);
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(negedge i_clk) begin : drive_bytes
        t_byte_item nxt;
        if (!i_rst_n || (i_valid && bytes_accepted != bytes_offered)) begin
            // hold a stalled item
        end else if (gap_left > 0) begin
            gap_left--;
            i_valid <= 1'b0;
        end else if (file_bytes.size() == 0 ||
                     (file_bytes[0].hold && lut_results_due.size() != 0)) begin
            i_valid <= 1'b0;
        end else begin
            nxt = file_bytes.pop_front();
            i_data_byte <= nxt.data;
            i_is_last   <= nxt.last;
            i_valid     <= 1'b1;
            bytes_offered++;
            gap_left = pick_gap();
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (!calm_stretch() && $urandom_range(0, 99) < 20)
                stall_left = burst_len();
        end
    end

    always @(posedge i_clk) begin : check_and_predict
        t_lut_result want;
        cycle_count++;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (lut_results_due.size() == 0)
                    report_mismatch("result with nothing due", 32'(o_kind), 32'd0);
                else begin
                    want = lut_results_due.pop_front();
                    if (want.kind == hflut_pkg::KIND_STATUS)
                        statuses_checked++;
                    else
                        channels_checked++;
                    if (o_kind !== want.kind)
                        report_mismatch("kind", 32'(o_kind), 32'(want.kind));
                    if (o_channel_bits !== want.channel_bits)
                        report_mismatch("channel_bits", o_channel_bits, want.channel_bits);
                    if (o_channel_number !== want.channel_number)
                        report_mismatch("channel_number", 32'(o_channel_number),
                                        32'(want.channel_number));
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_lut_dimension !== want.lut_dimension)
                        report_mismatch("lut_dimension", 32'(o_lut_dimension),
                                        32'(want.lut_dimension));
                    if (o_scale_bits !== want.scale_bits)
                        report_mismatch("scale_bits", o_scale_bits, want.scale_bits);
                    if (o_end_of_run !== want.end_of_run)
                        report_mismatch("end_of_run", 32'(o_end_of_run),
                                        32'(want.end_of_run));
                end
            end
            if (i_valid && !o_stall) begin
                parse_byte(i_data_byte, i_is_last);
                bytes_accepted++;
            end
        end
    end

    initial begin
        #1;
        while (file_bytes.size() != 0 || i_valid)
            @(negedge i_clk);
        while (lut_results_due.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (lut_results_due.size() != 0)
            report_mismatch("results never seen", 32'(lut_results_due.size()), 32'd0);
        $display("Covered %0d files in %0d bytes; checked %0d channels and %0d status results",
                 file_count, bytes_accepted, channels_checked, statuses_checked);
        $display("Status mix ok/trunc/rsvd/dim/scale/len/nonfinite: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4], status_tally[5], status_tally[6]);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", lut_results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
